>>> hw/rtl/ssraf_pkg.sv
// Shared constants, types and helpers of the SPI slave register-access framer.
`default_nettype none

package ssraf_pkg;

    localparam int REG_ROWS    = 4;
    localparam int ROW_BYTES   = 12;
    localparam int MAX_RESULTS = 12;
    localparam int TABLE_DEPTH = REG_ROWS * ROW_BYTES;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int ROW_W       = 2;
    localparam int COL_W       = 4;
    localparam int LEN_W       = 4;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(10);
    localparam logic [7:0]       BYTE_ONES     = 8'hFF;

    localparam logic       IN_MASTER = 1'b0;
    localparam logic       IN_TABLE  = 1'b1;
    localparam logic [7:0] OP_WRITE  = 8'd0;
    localparam logic [7:0] OP_READ   = 8'd1;

    localparam logic [1:0] OUT_REPLY = 2'd0;
    localparam logic [1:0] OUT_WDATA = 2'd1;
    localparam logic [1:0] OUT_ERROR = 2'd2;

    typedef enum logic [2:0] {
        ST_OPCODE,
        ST_REGISTER,
        ST_LENGTH,
        ST_DATA,
        ST_READ
    } state_t;

    function automatic logic [ADDR_W-1:0] table_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        table_addr = ADDR_W'(int'(row) * ROW_BYTES + int'(col));
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ssraf_if.sv
// Valid/ready channel interfaces for the framer input and result transfers.
`default_nettype none

interface ssraf_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic [1:0] table_row;
    logic [3:0] table_col;

    modport source (output valid, output kind, output data_byte, output table_row,
                    output table_col, input ready);
    modport sink (input valid, input kind, input data_byte, input table_row,
                  input table_col, output ready);
endinterface

interface ssraf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [7:0] target_register;
    logic [7:0] byte_position;
    logic       last;
    logic       bad_register;

    modport source (output valid, output out_kind, output out_byte, output target_register,
                    output byte_position, output last, output bad_register, input ready);
    modport sink (input valid, input out_kind, input out_byte, input target_register,
                  input byte_position, input last, input bad_register, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/spi_slave_register_access_framer.sv
// Top level of the SPI slave register-access framer.
//
// The req channel carries one transfer per master byte (kind 0) or per host
// table write (kind 1). Master frames are opcode, register index and length;
// a write frame then carries its data bytes. The rsp channel carries reply
// bytes, write data bytes and frame errors, one transfer each.
// An error or write data byte appears on rsp in the cycle after its input
// transfer. A read reply follows the length byte through ST_READ and mem_rd_reg
// and streams one byte per cycle from the table memory, up to 12 bytes, while
// the sink is ready; req stays not ready until the last reply byte is loaded.
// All other input transfers are taken one per cycle, also while a finished
// result waits in the output register, as long as the sink takes it that cycle.
// When the sink stalls, the output register holds its result and req waits.
// The max_read_length register is written through cfg_we and cfg_wdata.
// Reset clears the framer to await an opcode, sets max_read_length to 10 and
// marks every table byte as holding its row number, with no clearing pass.
`default_nettype none

module spi_slave_register_access_framer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [ssraf_pkg::LEN_W-1:0] cfg_wdata,
    ssraf_in_if.sink                        req,
    ssraf_out_if.source                     rsp
);
    import ssraf_pkg::*;

    state_t                 state_reg, state_next;
    logic                   is_read_reg, is_read_next;
    logic [7:0]             frame_reg_reg, frame_reg_next;
    logic [7:0]             frame_len_reg, frame_len_next;
    logic [7:0]             data_count_reg, data_count_next;
    logic [LEN_W-1:0]       rd_len_reg, rd_len_next;
    logic [LEN_W-1:0]       rd_pos_reg, rd_pos_next;
    logic [LEN_W-1:0]       max_len_reg;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [1:0]             out_kind_reg, out_kind_next;
    logic [7:0]             out_byte_reg, out_byte_next;
    logic [7:0]             target_reg, target_next;
    logic [7:0]             position_reg, position_next;
    logic                   last_reg, last_next;
    logic                   bad_reg, bad_next;

    logic [7:0]             table_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] tbl_valid_reg;
    logic [7:0]             mem_rd_reg;
    logic                   rd_valid_reg;

    logic                   out_free;
    logic                   accept;
    logic                   load_out;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [LEN_W-1:0]       lim;
    logic [LEN_W-1:0]       reply_count;
    logic                   bad_row;
    logic [7:0]             table_byte;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg != ST_READ) && out_free;
    assign accept    = req.valid && req.ready;

    assign lim         = (max_len_reg > LEN_W'(MAX_RESULTS)) ? LEN_W'(MAX_RESULTS) : max_len_reg;
    assign reply_count = (req.data_byte > {{(8-LEN_W){1'b0}}, lim}) ? lim
                                                                    : req.data_byte[LEN_W-1:0];
    assign bad_row     = frame_reg_reg >= 8'(REG_ROWS);
    assign table_byte  = rd_valid_reg ? mem_rd_reg : {{(8-ROW_W){1'b0}}, frame_reg_reg[ROW_W-1:0]};

    assign wr_addr = table_addr(req.table_row, req.table_col);
    assign wr_en   = accept && (req.kind == IN_TABLE)
                     && (int'(req.table_row) < REG_ROWS) && (int'(req.table_col) < ROW_BYTES);

    always_comb
    begin
        state_next      = state_reg;
        is_read_next    = is_read_reg;
        frame_reg_next  = frame_reg_reg;
        frame_len_next  = frame_len_reg;
        data_count_next = data_count_reg;
        rd_len_next     = rd_len_reg;
        rd_pos_next     = rd_pos_reg;
        load_out        = 1'b0;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;
        target_next     = target_reg;
        position_next   = position_reg;
        last_next       = last_reg;
        bad_next        = bad_reg;
        rd_en           = 1'b0;
        rd_addr         = table_addr(frame_reg_reg[ROW_W-1:0], '0);

        if (accept && (req.kind == IN_MASTER))
        begin
            case (state_reg)
                ST_OPCODE:
                begin
                    frame_reg_next  = BYTE_ONES;
                    frame_len_next  = '0;
                    data_count_next = '0;
                    if ((req.data_byte == OP_WRITE) || (req.data_byte == OP_READ))
                    begin
                        is_read_next = req.data_byte[0];
                        state_next   = ST_REGISTER;
                    end
                    else
                    begin
                        load_out      = 1'b1;
                        out_kind_next = OUT_ERROR;
                        out_byte_next = req.data_byte;
                        target_next   = BYTE_ONES;
                        position_next = '0;
                        last_next     = 1'b1;
                        bad_next      = 1'b0;
                    end
                end
                ST_REGISTER:
                begin
                    frame_reg_next = req.data_byte;
                    state_next     = ST_LENGTH;
                end
                ST_LENGTH:
                begin
                    frame_len_next  = req.data_byte;
                    data_count_next = '0;
                    if (is_read_reg)
                    begin
                        if (reply_count != '0)
                        begin
                            rd_len_next = reply_count;
                            rd_pos_next = '0;
                            rd_en       = 1'b1;
                            state_next  = ST_READ;
                        end
                        else
                        begin
                            state_next = ST_OPCODE;
                        end
                    end
                    else
                    begin
                        state_next = (req.data_byte == 8'd0) ? ST_OPCODE : ST_DATA;
                    end
                end
                ST_DATA:
                begin
                    load_out        = 1'b1;
                    out_kind_next   = OUT_WDATA;
                    out_byte_next   = req.data_byte;
                    target_next     = frame_reg_reg;
                    position_next   = data_count_reg;
                    last_next       = ({1'b0, data_count_reg} + 9'd1) >= {1'b0, frame_len_reg};
                    bad_next        = 1'b0;
                    data_count_next = data_count_reg + 8'd1;
                    if (last_next)
                    begin
                        state_next = ST_OPCODE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if ((state_reg == ST_READ) && out_free)
        begin
            load_out      = 1'b1;
            out_kind_next = OUT_REPLY;
            out_byte_next = (!bad_row && (int'(rd_pos_reg) < ROW_BYTES)) ? table_byte : BYTE_ONES;
            target_next   = frame_reg_reg;
            position_next = 8'(rd_pos_reg);
            last_next     = (rd_pos_reg + LEN_W'(1)) == rd_len_reg;
            bad_next      = bad_row;
            if (last_next)
            begin
                state_next = ST_OPCODE;
            end
            else
            begin
                rd_pos_next = rd_pos_reg + LEN_W'(1);
                rd_en       = 1'b1;
                rd_addr     = table_addr(frame_reg_reg[ROW_W-1:0], rd_pos_next);
            end
        end

        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && !rsp.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_OPCODE;
            is_read_reg    <= 1'b0;
            frame_reg_reg  <= BYTE_ONES;
            frame_len_reg  <= '0;
            data_count_reg <= '0;
            rd_len_reg     <= '0;
            rd_pos_reg     <= '0;
            max_len_reg    <= MAX_LEN_RESET;
            rsp_valid_reg  <= 1'b0;
            tbl_valid_reg  <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            is_read_reg    <= is_read_next;
            frame_reg_reg  <= frame_reg_next;
            frame_len_reg  <= frame_len_next;
            data_count_reg <= data_count_next;
            rd_len_reg     <= rd_len_next;
            rd_pos_reg     <= rd_pos_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
            if (wr_en)
            begin
                tbl_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= tbl_valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= req.data_byte;
        end
        if (rd_en)
        begin
            mem_rd_reg <= table_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        target_reg   <= target_next;
        position_reg <= position_next;
        last_reg     <= last_next;
        bad_reg      <= bad_next;
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.out_kind        = out_kind_reg;
    assign rsp.out_byte        = out_byte_reg;
    assign rsp.target_register = target_reg;
    assign rsp.byte_position   = position_reg;
    assign rsp.last            = last_reg;
    assign rsp.bad_register    = bad_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ssraf_checker.sv
// Port-level assertions for the framer result channel, bound to the top level.
`default_nettype none

module ssraf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [1:0] out_kind,
    input wire logic [7:0] out_byte,
    input wire logic [7:0] target_register,
    input wire logic [7:0] byte_position,
    input wire logic       last,
    input wire logic       bad_register
);
    import ssraf_pkg::*;

    // A stalled result transfer keeps its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_kind) && $stable(out_byte)
            && $stable(target_register) && $stable(byte_position) && $stable(last)
            && $stable(bad_register))
        else $error("result changed while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (out_kind == OUT_REPLY) || (out_kind == OUT_WDATA)
            || (out_kind == OUT_ERROR))
        else $error("illegal result kind");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (out_kind == OUT_ERROR) |-> last && (target_register == BYTE_ONES)
            && (byte_position == 8'd0) && !bad_register)
        else $error("malformed frame error");

    a_bad_reply: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (out_kind == OUT_REPLY) && bad_register |->
            (out_byte == BYTE_ONES) && (target_register >= 8'(REG_ROWS)))
        else $error("bad register reply carries data");

    a_wdata_good: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (out_kind == OUT_WDATA) |-> !bad_register)
        else $error("write data flagged as bad register");

endmodule

bind spi_slave_register_access_framer ssraf_checker u_ssraf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .out_kind        (rsp.out_kind),
    .out_byte        (rsp.out_byte),
    .target_register (rsp.target_register),
    .byte_position   (rsp.byte_position),
    .last            (rsp.last),
    .bad_register    (rsp.bad_register)
);

`default_nettype wire

>>> dv/tb.sv
// Testbench for the SPI slave register-access framer with directed and random frames.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssraf_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 50;
    localparam int N_PHASES     = 5;
    localparam int N_DIRECTED   = 24;
    localparam int SETTLE_GAP   = 8;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_CAP    = 50;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [1:0] table_row;
        logic [3:0] table_col;
    } req_item_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [7:0] target_register;
        logic [7:0] byte_position;
        logic       last;
        logic       bad_register;
    } rsp_beat_t;

    typedef struct packed {
        req_item_t item;
        logic      typed;
        rsp_beat_t want;
    } directed_row_t;

    typedef enum logic [1:0] {
        WAIT_OPCODE,
        WAIT_REGISTER,
        WAIT_LENGTH,
        WAIT_DATA
    } framer_step_t;

    localparam directed_row_t DIRECTED [N_DIRECTED] = '{
        '{'{IN_MASTER, 8'h02, 2'd3, 4'd15}, 1'b1,
          '{OUT_ERROR, 8'h02, BYTE_ONES, 8'h00, 1'b1, 1'b0}},
        '{'{IN_MASTER, 8'hFF, 2'd0, 4'd0}, 1'b1,
          '{OUT_ERROR, 8'hFF, BYTE_ONES, 8'h00, 1'b1, 1'b0}},
        '{'{IN_MASTER, OP_READ, 2'd1, 4'd5}, 1'b0, '0},
        '{'{IN_MASTER, 8'h02, 2'd2, 4'd10}, 1'b0, '0},
        '{'{IN_MASTER, 8'h01, 2'd0, 4'd0}, 1'b1,
          '{OUT_REPLY, 8'h02, 8'h02, 8'h00, 1'b1, 1'b0}},
        '{'{IN_MASTER, OP_READ, 2'd0, 4'd0}, 1'b0, '0},
        '{'{IN_MASTER, 8'hFF, 2'd0, 4'd0}, 1'b0, '0},
        '{'{IN_MASTER, 8'h01, 2'd0, 4'd0}, 1'b1,
          '{OUT_REPLY, BYTE_ONES, 8'hFF, 8'h00, 1'b1, 1'b1}},
        '{'{IN_MASTER, OP_READ, 2'd0, 4'd0}, 1'b0, '0},
        '{'{IN_MASTER, 8'h03, 2'd0, 4'd0}, 1'b0, '0},
        '{'{IN_MASTER, 8'hFF, 2'd3, 4'd15}, 1'b0, '0},
        '{'{IN_MASTER, OP_READ, 2'd0, 4'd0}, 1'b0, '0},
        '{'{IN_MASTER, 8'h01, 2'd0, 4'd0}, 1'b0, '0},
        '{'{IN_MASTER, 8'h00, 2'd0, 4'd0}, 1'b0, '0},
        '{'{IN_MASTER, OP_WRITE, 2'd0, 4'd0}, 1'b0, '0},
        '{'{IN_MASTER, 8'h80, 2'd0, 4'd0}, 1'b0, '0},
        '{'{IN_MASTER, 8'h00, 2'd0, 4'd0}, 1'b0, '0},
        '{'{IN_TABLE, 8'hA5, 2'd3, 4'd11}, 1'b0, '0},
        '{'{IN_TABLE, 8'h5A, 2'd3, 4'd15}, 1'b0, '0},
        '{'{IN_MASTER, OP_WRITE, 2'd0, 4'd0}, 1'b0, '0},
        '{'{IN_MASTER, 8'h00, 2'd0, 4'd0}, 1'b0, '0},
        '{'{IN_MASTER, 8'h02, 2'd0, 4'd0}, 1'b0, '0},
        '{'{IN_MASTER, 8'hFF, 2'd0, 4'd0}, 1'b1,
          '{OUT_WDATA, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0}},
        '{'{IN_MASTER, 8'h00, 2'd0, 4'd0}, 1'b1,
          '{OUT_WDATA, 8'h00, 8'h00, 8'h01, 1'b1, 1'b0}}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [LEN_W-1:0]     cfg_wdata;

    ssraf_in_if  req_ch ();
    ssraf_out_if rsp_ch ();

    spi_slave_register_access_framer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    framer_step_t     step;
    logic             read_frame;
    logic [7:0]       frame_reg;
    logic [7:0]       frame_len;
    logic [7:0]       data_cnt;
    logic [LEN_W-1:0] read_cap;
    logic [7:0]       reg_bytes [REG_ROWS][ROW_BYTES];

    rsp_beat_t beats_due [$];
    rsp_beat_t fresh_beats [$];
    int        mismatches;
    int        results_seen;
    int        phase_items;
    int        cycle_count;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
        begin
            $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        end
        mismatches++;
    endtask

    function automatic string beat_text(input rsp_beat_t b);
        return $sformatf("kind %0d byte %02h reg %02h pos %0d last %b bad %b",
                         b.out_kind, b.out_byte, b.target_register, b.byte_position,
                         b.last, b.bad_register);
    endfunction

    function automatic int pick_run();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 19)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Fills fresh_beats with the results one accepted transfer causes.
    function automatic void predict_framer_results(input req_item_t it);
        rsp_beat_t beat;
        int        lim;
        int        n;
        logic      bad;
        fresh_beats.delete();
        if (it.kind == IN_TABLE)
        begin
            if (int'(it.table_col) < ROW_BYTES)
            begin
                reg_bytes[it.table_row][it.table_col] = it.data_byte;
            end
            return;
        end
        case (step)
            WAIT_REGISTER:
            begin
                frame_reg = it.data_byte;
                step = WAIT_LENGTH;
            end
            WAIT_LENGTH:
            begin
                frame_len = it.data_byte;
                data_cnt = 8'd0;
                if (read_frame)
                begin
                    lim = (int'(read_cap) > MAX_RESULTS) ? MAX_RESULTS : int'(read_cap);
                    n = (int'(it.data_byte) > lim) ? lim : int'(it.data_byte);
                    bad = (int'(frame_reg) >= REG_ROWS);
                    for (int k = 0; k < n; k++)
                    begin
                        beat.out_kind = OUT_REPLY;
                        beat.out_byte = (!bad && k < ROW_BYTES)
                                        ? reg_bytes[frame_reg[ROW_W-1:0]][k] : BYTE_ONES;
                        beat.target_register = frame_reg;
                        beat.byte_position = 8'(k);
                        beat.last = (k + 1 == n);
                        beat.bad_register = bad;
                        fresh_beats.push_back(beat);
                    end
                    step = WAIT_OPCODE;
                end
                else
                begin
                    step = (it.data_byte == 8'd0) ? WAIT_OPCODE : WAIT_DATA;
                end
            end
            WAIT_DATA:
            begin
                beat.out_kind = OUT_WDATA;
                beat.out_byte = it.data_byte;
                beat.target_register = frame_reg;
                beat.byte_position = data_cnt;
                beat.last = (int'(data_cnt) + 1 >= int'(frame_len));
                beat.bad_register = 1'b0;
                fresh_beats.push_back(beat);
                data_cnt = data_cnt + 8'd1;
                if (beat.last)
                begin
                    step = WAIT_OPCODE;
                end
            end
            default:
            begin
                frame_reg = BYTE_ONES;
                frame_len = 8'd0;
                data_cnt = 8'd0;
                if (it.data_byte == OP_WRITE || it.data_byte == OP_READ)
                begin
                    read_frame = (it.data_byte == OP_READ);
                    step = WAIT_REGISTER;
                end
                else
                begin
                    beat.out_kind = OUT_ERROR;
                    beat.out_byte = it.data_byte;
                    beat.target_register = BYTE_ONES;
                    beat.byte_position = 8'd0;
                    beat.last = 1'b1;
                    beat.bad_register = 1'b0;
                    fresh_beats.push_back(beat);
                    step = WAIT_OPCODE;
                end
            end
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the transfer completes.
    task automatic deliver_item(input req_item_t it, input logic typed, input rsp_beat_t want);
        int gap;
        gap = ($urandom_range(0, 1) == 0) ? 0 : pick_run();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind <= it.kind;
        req_ch.data_byte <= it.data_byte;
        req_ch.table_row <= it.table_row;
        req_ch.table_col <= it.table_col;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_framer_results(it);
        if (typed)
        begin
            beats_due.push_back(want);
        end
        else
        begin
            foreach (fresh_beats[i])
            begin
                beats_due.push_back(fresh_beats[i]);
            end
        end
        phase_items++;
    endtask

    function automatic req_item_t random_table_write();
        req_item_t it;
        it.kind = IN_TABLE;
        it.data_byte = 8'($urandom);
        it.table_row = 2'($urandom);
        it.table_col = 4'($urandom_range(0, 15));
        return it;
    endfunction

    task automatic master_byte(input logic [7:0] b);
        req_item_t it;
        if ($urandom_range(0, 11) == 0)
        begin
            deliver_item(random_table_write(), 1'b0, '0);
        end
        it.kind = IN_MASTER;
        it.data_byte = b;
        it.table_row = 2'($urandom);
        it.table_col = 4'($urandom);
        deliver_item(it, 1'b0, '0);
    endtask

    task automatic random_frame();
        int         r;
        int         len;
        int         sent;
        logic [7:0] idx;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            master_byte(OP_READ);
            idx = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            master_byte(idx);
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 14);
            master_byte(8'(len));
        end
        else if (r < 80)
        begin
            master_byte(OP_WRITE);
            master_byte(8'($urandom));
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
            master_byte(8'(len));
            sent = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
            repeat (sent) master_byte(8'($urandom));
        end
        else if (r < 90)
        begin
            deliver_item(random_table_write(), 1'b0, '0);
        end
        else
        begin
            master_byte(8'($urandom));
        end
    endtask

    always @(posedge clk)
    begin : watch_rsp
        rsp_beat_t got;
        rsp_beat_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{rsp_ch.out_kind, rsp_ch.out_byte, rsp_ch.target_register,
                    rsp_ch.byte_position, rsp_ch.last, rsp_ch.bad_register};
            if (beats_due.size() == 0)
            begin
                report_mismatch({"result with none due: ", beat_text(got)});
            end
            else
            begin
                want = beats_due.pop_front();
                if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
                    got.target_register !== want.target_register ||
                    got.byte_position !== want.byte_position ||
                    got.last !== want.last || got.bad_register !== want.bad_register)
                begin
                    report_mismatch($sformatf("result %0d got %s, want %s", results_seen,
                                              beat_text(got), beat_text(want)));
                end
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int  run;
        logic stalled;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            run = pick_run();
            stalled = ($urandom_range(0, 2) == 0);
            repeat (run)
            begin
                @(posedge clk);
                rsp_ch.ready <= !stalled;
            end
        end
    end

    initial
    begin
        logic [LEN_W-1:0] cfg_plan [N_PHASES];
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.kind <= IN_MASTER;
        req_ch.data_byte <= 8'd0;
        req_ch.table_row <= 2'd0;
        req_ch.table_col <= 4'd0;
        mismatches = 0;
        results_seen = 0;
        cycle_count = 0;
        step = WAIT_OPCODE;
        read_frame = 1'b0;
        frame_reg = BYTE_ONES;
        frame_len = 8'd0;
        data_cnt = 8'd0;
        read_cap = MAX_LEN_RESET;
        for (int r = 0; r < REG_ROWS; r++)
        begin
            for (int c = 0; c < ROW_BYTES; c++)
            begin
                reg_bytes[r][c] = 8'(r);
            end
        end
        cfg_plan = '{4'd15, 4'd0, 4'd1, 4'd12, 4'd0};
        cfg_plan[N_PHASES-1] = LEN_W'($urandom_range(2, 11));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            deliver_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            req_ch.valid <= 1'b0;
            while (beats_due.size() != 0) @(posedge clk);
            repeat (SETTLE_GAP) @(posedge clk);
            cfg_we <= 1'b1;
            cfg_wdata <= cfg_plan[p];
            @(posedge clk);
            cfg_we <= 1'b0;
            read_cap = cfg_plan[p];
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) random_frame();
        end

        req_ch.valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (beats_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", beats_due.size()));
        end
        if (mismatches == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
